### rtl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while in reset
`define GLPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glps assertion failed");

// same-cycle implication, also watched around reset
`define GLPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("glps assertion failed");

`endif

### rtl/glps_pkg.sv
`default_nettype none

package glps_pkg;

    localparam int COORD_BITS     = 6;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   delta_t;
    typedef logic [QUEUE_PTR_BITS-1:0] qptr_t;
    typedef logic [QUEUE_PTR_BITS:0]   qcount_t;

    typedef struct packed {
        coord_t start_maj;
        coord_t start_min;
        coord_t mag_maj;
        coord_t mag_min;
        logic   maj_neg;
        logic   min_neg;
        logic   x_major;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

`default_nettype wire

### rtl/glps_queue.sv
`default_nettype none

module glps_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire glps_pkg::cmd_t   push_cmd,
    input  wire logic             pop,
    output glps_pkg::cmd_t        pop_cmd,
    output glps_pkg::q_stat_t     stat
);

    glps_pkg::cmd_t    entry_reg [glps_pkg::QUEUE_DEPTH];
    glps_pkg::qptr_t   wr_ptr_reg;
    glps_pkg::qptr_t   wr_ptr_next;
    glps_pkg::qptr_t   rd_ptr_reg;
    glps_pkg::qptr_t   rd_ptr_next;
    glps_pkg::qcount_t count_reg;
    glps_pkg::qcount_t count_next;

    always_comb
    begin
        stat.full   = (count_reg == glps_pkg::qcount_t'(glps_pkg::QUEUE_DEPTH));
        stat.empty  = (count_reg == '0);
        pop_cmd     = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == glps_pkg::qptr_t'(glps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + glps_pkg::qptr_t'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == glps_pkg::qptr_t'(glps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + glps_pkg::qptr_t'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + glps_pkg::qcount_t'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - glps_pkg::qcount_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/glps_front.sv
`default_nettype none

module glps_front (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire glps_pkg::coord_t  start_x,
    input  wire glps_pkg::coord_t  start_y,
    input  wire glps_pkg::coord_t  end_x,
    input  wire glps_pkg::coord_t  end_y,
    input  wire glps_pkg::q_stat_t stat,
    output logic                   push,
    output glps_pkg::cmd_t         push_cmd
);

    glps_pkg::delta_t dx;
    glps_pkg::delta_t dy;
    glps_pkg::delta_t abs_x;
    glps_pkg::delta_t abs_y;
    glps_pkg::coord_t mag_x;
    glps_pkg::coord_t mag_y;
    logic             x_major;

    always_comb
    begin
        dx      = {1'b0, end_x} - {1'b0, start_x};
        dy      = {1'b0, end_y} - {1'b0, start_y};
        abs_x   = dx[glps_pkg::COORD_BITS] ? (~dx + glps_pkg::delta_t'(1)) : dx;
        abs_y   = dy[glps_pkg::COORD_BITS] ? (~dy + glps_pkg::delta_t'(1)) : dy;
        mag_x   = abs_x[glps_pkg::COORD_BITS-1:0];
        mag_y   = abs_y[glps_pkg::COORD_BITS-1:0];
        x_major = (mag_x > mag_y);

        push_cmd.x_major = x_major;
        if (x_major)
        begin
            push_cmd.start_maj = start_x;
            push_cmd.start_min = start_y;
            push_cmd.mag_maj   = mag_x;
            push_cmd.mag_min   = mag_y;
            push_cmd.maj_neg   = dx[glps_pkg::COORD_BITS];
            push_cmd.min_neg   = dy[glps_pkg::COORD_BITS];
        end
        else
        begin
            push_cmd.start_maj = start_y;
            push_cmd.start_min = start_x;
            push_cmd.mag_maj   = mag_y;
            push_cmd.mag_min   = mag_x;
            push_cmd.maj_neg   = dy[glps_pkg::COORD_BITS];
            push_cmd.min_neg   = dx[glps_pkg::COORD_BITS];
        end

        in_ready = !stat.full;
        // a zero-length line is taken and dropped
        push     = in_valid && in_ready && (push_cmd.mag_maj != '0);
    end

endmodule

`default_nettype wire

### rtl/glps_back.sv
`default_nettype none

module glps_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire glps_pkg::q_stat_t stat,
    input  wire glps_pkg::cmd_t    pop_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output glps_pkg::coord_t       point_x,
    output glps_pkg::coord_t       point_y,
    output logic                   last
);

    glps_pkg::back_state_t state_reg;
    glps_pkg::back_state_t state_next;
    glps_pkg::coord_t      maj_reg;
    glps_pkg::coord_t      maj_next;
    glps_pkg::coord_t      min_reg;
    glps_pkg::coord_t      min_next;
    glps_pkg::coord_t      rem_reg;
    glps_pkg::coord_t      rem_next;
    glps_pkg::coord_t      left_reg;
    glps_pkg::coord_t      left_next;
    glps_pkg::coord_t      amaj_reg;
    glps_pkg::coord_t      amin_reg;
    logic                  maj_neg_reg;
    logic                  min_neg_reg;
    logic                  x_major_reg;
    logic                  load;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    glps_pkg::coord_t      px_reg;
    glps_pkg::coord_t      px_next;
    glps_pkg::coord_t      py_reg;
    glps_pkg::coord_t      py_next;
    logic                  last_reg;
    logic                  last_next;
    glps_pkg::delta_t      rem_sum;
    logic                  min_step;

    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        maj_next       = maj_reg;
        min_next       = min_reg;
        rem_next       = rem_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        load           = 1'b0;

        // remainder of minor * step / major, carried one step at a time
        rem_sum  = {1'b0, rem_reg} + {1'b0, amin_reg};
        min_step = (rem_sum >= {1'b0, amaj_reg});

        case (state_reg)
            glps_pkg::BACK_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    load       = 1'b1;
                    maj_next   = pop_cmd.start_maj;
                    min_next   = pop_cmd.start_min;
                    rem_next   = '0;
                    left_next  = pop_cmd.mag_maj;
                    state_next = glps_pkg::BACK_RUN;
                end
            end
            glps_pkg::BACK_RUN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    maj_next = maj_neg_reg ? maj_reg - glps_pkg::coord_t'(1)
                                           : maj_reg + glps_pkg::coord_t'(1);
                    if (min_step)
                    begin
                        rem_next = glps_pkg::coord_t'(rem_sum - {1'b0, amaj_reg});
                        min_next = min_neg_reg ? min_reg - glps_pkg::coord_t'(1)
                                               : min_reg + glps_pkg::coord_t'(1);
                    end
                    else
                    begin
                        rem_next = glps_pkg::coord_t'(rem_sum);
                    end
                    left_next      = left_reg - glps_pkg::coord_t'(1);
                    out_valid_next = 1'b1;
                    px_next        = x_major_reg ? maj_next : min_next;
                    py_next        = x_major_reg ? min_next : maj_next;
                    last_next      = (left_reg == glps_pkg::coord_t'(1));
                    if (left_reg == glps_pkg::coord_t'(1))
                    begin
                        state_next = glps_pkg::BACK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = glps_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glps_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maj_reg  <= maj_next;
        min_reg  <= min_next;
        rem_reg  <= rem_next;
        left_reg <= left_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
        if (load)
        begin
            amaj_reg    <= pop_cmd.mag_maj;
            amin_reg    <= pop_cmd.mag_min;
            maj_neg_reg <= pop_cmd.maj_neg;
            min_neg_reg <= pop_cmd.min_neg;
            x_major_reg <= pop_cmd.x_major;
        end
    end

endmodule

`default_nettype wire

### rtl/grid_line_point_stepper_core.sv
// Line point stepper on a 64 by 64 grid. Each input word gives a start and an end
// point; the block emits the points of the line after the start up to and including
// the end, one output word per point, with last set on the end point. The axis with
// the larger distance is the major axis (y on a tie); each point moves one along it,
// and the minor offset at step k is floor(minor * k / major), kept exactly with a
// running remainder. An equal start and end produces no output. The front classifier
// takes a word in the cycle it arrives while its two-entry command queue has room; the
// stepping unit then picks up one command in its idle state and steps through its
// n = max(|dx|, |dy|) points, at most 63, in its run state, holding while out_ready is
// low; it takes the next command only once the end point has been produced.
`default_nettype none

module grid_line_point_stepper_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire glps_pkg::coord_t start_x,
    input  wire glps_pkg::coord_t start_y,
    input  wire glps_pkg::coord_t end_x,
    input  wire glps_pkg::coord_t end_y,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output glps_pkg::coord_t      point_x,
    output glps_pkg::coord_t      point_y,
    output logic                  last
);

    glps_pkg::q_stat_t stat;
    glps_pkg::cmd_t    push_cmd;
    glps_pkg::cmd_t    pop_cmd;
    logic              push;
    logic              pop;

    glps_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .stat     (stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    glps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (stat)
    );

    glps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last)
    );

endmodule

`default_nettype wire

### rtl/glps_checker.sv
`default_nettype none
`include "assert_macros.svh"

module glps_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire glps_pkg::coord_t start_x,
    input wire glps_pkg::coord_t start_y,
    input wire glps_pkg::coord_t end_x,
    input wire glps_pkg::coord_t end_y,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire glps_pkg::coord_t point_x,
    input wire glps_pkg::coord_t point_y,
    input wire logic             last
);

    // stalled output word holds
    `GLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(last))

    // nothing on the output right after reset
    `GLPS_ASSERT_NOW(a_reset_quiet, $rose(rst_n), !out_valid)

    // points of one line follow without a gap
    `GLPS_ASSERT_NEXT(a_line_no_gap, out_valid && out_ready && !last, out_valid)

    // neighboring points of one line differ by at most one on each axis
    `GLPS_ASSERT_NEXT(a_line_adjacent, out_valid && out_ready && !last, (point_x == $past(point_x) || point_x == glps_pkg::coord_t'($past(point_x) + 1'b1) || point_x == glps_pkg::coord_t'($past(point_x) - 1'b1)) && (point_y == $past(point_y) || point_y == glps_pkg::coord_t'($past(point_y) + 1'b1) || point_y == glps_pkg::coord_t'($past(point_y) - 1'b1)))

endmodule

bind grid_line_point_stepper_core glps_checker u_glps_checker (.*);

`default_nettype wire
